/* rtl/memory_value_scan_filter_top_defines.svh */
// assertion macros shared by the memory value scan filter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef MEMORY_VALUE_SCAN_FILTER_TOP_DEFINES_SVH
`define MEMORY_VALUE_SCAN_FILTER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MVSF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define MVSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mvsf_pkg.sv */
// shared types, constants and helpers of the memory value scan filter
// no dependencies; imported by every module of the block
package mvsf_pkg;

  localparam int IDX_W       = 12;
  localparam int VAL_W       = 32;
  localparam int COUNT_W     = 13;
  localparam int EB_W        = 3;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int MAX_STORE   = 2 ** IDX_W;
  localparam int REGION_ELEMENTS_DEF = 4096;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 13'd8191;
  localparam logic [VAL_W-1:0]   BYTE_MASK   = 32'h0000_00ff;
  localparam logic [EB_W-1:0]    EB_RESET    = 3'd4;
  localparam logic [EB_W-1:0]    EB_ONE      = 3'd1;
  localparam logic [EB_W-1:0]    EB_TWO      = 3'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COMPARE_VALUE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ELEMENT_BYTES = 2'd2;

  typedef enum logic [1:0] {
    MODE_ANY   = 2'd0,
    MODE_EQUAL = 2'd1,
    MODE_INC   = 2'd2,
    MODE_DEC   = 2'd3
  } search_mode_t;

  typedef struct packed {
    search_mode_t      search_mode;
    logic [VAL_W-1:0]  compare_value;
    logic [EB_W-1:0]   element_bytes;
  } cfg_t;

  typedef struct packed {
    logic               still_candidate;
    logic [COUNT_W-1:0] match_count;
    logic               pass_skipped;
    logic               pass_done;
  } out_item_t;

  function automatic logic [VAL_W-1:0] width_mask(input logic [EB_W-1:0] eb);
    logic [VAL_W-1:0] m;
    if (eb == EB_ONE) begin
      m = BYTE_MASK;
    end else if (eb == EB_TWO) begin
      m = (BYTE_MASK << 8) | BYTE_MASK;
    end else begin
      m = '1;
    end
    return m;
  endfunction

endpackage

/* rtl/mvsf_snap_ram.sv */
// snapshot store: one write port, one registered read port
// depends on mvsf_pkg
module mvsf_snap_ram #(
  parameter int DEPTH = mvsf_pkg::MAX_STORE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [mvsf_pkg::VAL_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic [mvsf_pkg::VAL_W-1:0] rdata
);
  import mvsf_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/mvsf_cand_ram.sv */
// candidate bit store with a set-to-one sweep after reset
// depends on mvsf_pkg
module mvsf_cand_ram #(
  parameter int DEPTH = mvsf_pkg::MAX_STORE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata,
  output logic          clear_done
);
  import mvsf_pkg::*;

  logic          mem [DEPTH];
  logic          clearing;
  logic [AW-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= 1'b1;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign clear_done = !clearing;

endmodule

/* rtl/mvsf_update.sv */
// per-element filter decision, pass bookkeeping and running count
// depends on mvsf_pkg
module mvsf_update #(
  parameter int REGION_ELEMENTS = mvsf_pkg::REGION_ELEMENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mvsf_pkg::cfg_t               cfg,
  input  logic                         advance,
  input  logic [mvsf_pkg::IDX_W-1:0]   element_index,
  input  logic [mvsf_pkg::VAL_W-1:0]   element_value,
  input  logic                         first_of_pass,
  input  logic                         last_of_pass,
  input  logic [mvsf_pkg::VAL_W-1:0]   snap_old,
  input  logic                         cand_old,
  output logic                         wr_en,
  output logic [mvsf_pkg::VAL_W-1:0]   wr_snap,
  output logic                         wr_cand,
  output mvsf_pkg::out_item_t          result
);
  import mvsf_pkg::*;

  logic               skip_active, skip_active_next;
  logic [COUNT_W-1:0] running_count, running_count_next;
  logic [COUNT_W-1:0] previous_pass_count, previous_pass_count_next;

  logic [VAL_W-1:0]   mask, val, prev;
  logic [COUNT_W-1:0] count_base;
  logic               in_range, hit, count_inc, cand_new, still;

  assign in_range = (32'(element_index) < REGION_ELEMENTS);
  assign mask     = width_mask(cfg.element_bytes);
  assign val      = element_value & mask;
  assign prev     = snap_old & mask;

  always_comb begin
    unique case (cfg.search_mode)
      MODE_EQUAL: hit = (val == (cfg.compare_value & mask));
      MODE_INC:   hit = (val > prev);
      MODE_DEC:   hit = (val < prev);
      default:    hit = 1'b1;
    endcase
  end

  always_comb begin
    skip_active_next = first_of_pass ? (previous_pass_count == '0) : skip_active;
    count_base       = first_of_pass ? '0 : running_count;

    cand_new  = cand_old;
    count_inc = 1'b0;
    if (cfg.search_mode == MODE_ANY) begin
      cand_new  = 1'b1;
      count_inc = 1'b1;
    end else if (cand_old) begin
      cand_new  = hit;
      count_inc = hit;
    end

    wr_en = in_range && !skip_active_next;

    priority if (!in_range) begin
      still = 1'b0;
    end else if (skip_active_next) begin
      still = cand_old;
    end else begin
      still = cand_new;
    end

    if (wr_en && count_inc && (count_base != COUNT_MAX)) begin
      running_count_next = count_base + 1'b1;
    end else begin
      running_count_next = count_base;
    end

    previous_pass_count_next = previous_pass_count;
    if (last_of_pass && !skip_active_next) begin
      previous_pass_count_next = running_count_next;
    end
  end

  assign wr_snap = val;
  assign wr_cand = cand_new;

  assign result.still_candidate = still;
  assign result.match_count     = running_count_next;
  assign result.pass_skipped    = skip_active_next;
  assign result.pass_done       = last_of_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_active         <= 1'b0;
      running_count       <= COUNT_RESET;
      previous_pass_count <= COUNT_RESET;
    end else if (advance) begin
      skip_active         <= skip_active_next;
      running_count       <= running_count_next;
      previous_pass_count <= previous_pass_count_next;
    end
  end

endmodule

/* rtl/memory_value_scan_filter_top.sv */
// top level of the memory value scan filter: config registers, read stage,
// update stage and output register; depends on mvsf_pkg, mvsf_snap_ram,
// mvsf_cand_ram, mvsf_update and memory_value_scan_filter_top_defines.svh
//
// s_axis carries one region element per transfer: tdata holds the index and
// the value, tuser flags the first element of a scan pass, tlast the last one.
// m_axis returns one result per element, in order: candidate bit and running
// match count on tdata, skipped-pass flag on tuser, tlast echoing the pass end.
// cfg_we/cfg_addr/cfg_wdata write search mode, compare value and element
// width; write them only while no element is in flight.
// pipeline: update stage registers, then output register; one element is taken
// every cycle while m_axis does not stall. both memories are read at the input
// transfer and written as the element leaves the update stage; a same-entry
// access in back-to-back elements is forwarded.
// reset: rst is synchronous, active high; afterwards a sweep over
// min(REGION_ELEMENTS, 4096) entries sets the candidate memory to all ones
// while s_axis_tready stays low; config writes are still taken.
// stall: a stalled m_axis holds the result; the update stage and then the
// input stop in turn, so no transfer is lost or repeated.
module memory_value_scan_filter_top #(
  parameter int REGION_ELEMENTS = mvsf_pkg::REGION_ELEMENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // config write port
  input  logic                             cfg_we,
  input  logic [mvsf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mvsf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [47:0]                      s_axis_tdata,  // [11:0] element_index, [43:12] element_value, [47:44] zero
  input  logic                             s_axis_tuser,  // [0] first_of_pass
  input  logic                             s_axis_tlast,  // last_of_pass
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [0] still_candidate, [13:1] match_count, [15:14] zero
  output logic                             m_axis_tuser,  // [0] pass_skipped
  output logic                             m_axis_tlast   // pass_done
);
  import mvsf_pkg::*;
  `include "memory_value_scan_filter_top_defines.svh"

  // the stores never need more entries than a 12-bit index can reach
  localparam int STORE_DEPTH = (REGION_ELEMENTS < MAX_STORE) ? REGION_ELEMENTS : MAX_STORE;
  localparam int AW          = $clog2(STORE_DEPTH);

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.search_mode   <= MODE_ANY;
      cfg.compare_value <= '0;
      cfg.element_bytes <= EB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SEARCH_MODE:   cfg.search_mode   <= search_mode_t'(cfg_wdata[1:0]);
        REG_COMPARE_VALUE: cfg.compare_value <= cfg_wdata[VAL_W-1:0];
        REG_ELEMENT_BYTES: cfg.element_bytes <= cfg_wdata[EB_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // input unpacking
  logic [IDX_W-1:0] in_idx;
  logic [VAL_W-1:0] in_val;
  logic [AW-1:0]    in_addr;

  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_val  = s_axis_tdata[IDX_W +: VAL_W];
  assign in_addr = in_idx[AW-1:0];

  // update stage registers: element waiting for its memory read data
  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic [VAL_W-1:0] s1_val;
  logic             s1_first, s1_last;
  logic             s1_fwd;        // same entry written on the edge of the read
  logic [VAL_W-1:0] s1_fwd_snap;
  logic             s1_fwd_cand;
  logic [AW-1:0]    s1_addr;

  // output register
  logic      out_valid;
  out_item_t out_item;

  logic             s1_adv, in_xfer, clear_done;
  logic             upd_wr_en, mem_we;
  logic [VAL_W-1:0] upd_snap, snap_rd, snap_old;
  logic             upd_cand, cand_rd, cand_old;
  out_item_t        upd_result;

  assign s1_addr = s1_idx[AW-1:0];

  // the update stage moves on whenever the output register is free or drains
  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = clear_done && (!s1_valid || s1_adv);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign mem_we        = s1_adv && upd_wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_idx      <= in_idx;
      s1_val      <= in_val;
      s1_first    <= s_axis_tuser;
      s1_last     <= s_axis_tlast;
      // memory reads this edge miss the write made on the same edge
      s1_fwd      <= mem_we && (s1_addr == in_addr);
      s1_fwd_snap <= upd_snap;
      s1_fwd_cand <= upd_cand;
    end
  end

  assign snap_old = s1_fwd ? s1_fwd_snap : snap_rd;
  assign cand_old = s1_fwd ? s1_fwd_cand : cand_rd;

  mvsf_snap_ram #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_snap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_addr),
    .wdata (upd_snap),
    .re    (in_xfer),
    .raddr (in_addr),
    .rdata (snap_rd)
  );

  mvsf_cand_ram #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_cand (
    .clk        (clk),
    .rst        (rst),
    .we         (mem_we),
    .waddr      (s1_addr),
    .wdata      (upd_cand),
    .re         (in_xfer),
    .raddr      (in_addr),
    .rdata      (cand_rd),
    .clear_done (clear_done)
  );

  mvsf_update #(
    .REGION_ELEMENTS (REGION_ELEMENTS)
  ) u_update (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .advance       (s1_adv),
    .element_index (s1_idx),
    .element_value (s1_val),
    .first_of_pass (s1_first),
    .last_of_pass  (s1_last),
    .snap_old      (snap_old),
    .cand_old      (cand_old),
    .wr_en         (upd_wr_en),
    .wr_snap       (upd_snap),
    .wr_cand       (upd_cand),
    .result        (upd_result)
  );

  // output register, loaded as the update stage retires an element
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item <= upd_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_item.match_count, out_item.still_candidate};
  assign m_axis_tuser  = out_item.pass_skipped;
  assign m_axis_tlast  = out_item.pass_done;

  // a skipped pass never counts anything
  `MVSF_ASSERT_SAME(a_skip_count_zero, clk, rst, out_valid && out_item.pass_skipped, out_item.match_count == '0, "skipped pass reports a nonzero count")
  // the candidate sweep keeps the input closed right after reset
  `MVSF_ASSERT_SAME(a_sweep_blocks_input, clk, rst, $past(rst), !s_axis_tready, "input open before candidate sweep")
  // an element held in the update stage is not dropped
  `MVSF_ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_idx), "update stage lost a stalled element")
  // every input transfer reaches the update stage
  `MVSF_ASSERT_NEXT(a_xfer_lands, clk, rst, in_xfer, s1_valid, "input transfer not held in update stage")

endmodule
